### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the Life generation stream checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define LGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every rising edge, reset included.
`define LGS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lgs_pkg.sv
// ---------------------------------------------------------------------------
// lgs_pkg
// Shared constants, the request bundle type and the Life rule.
// ---------------------------------------------------------------------------
package lgs_pkg;

    localparam int GRID_MAX_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_W           = 7;
    localparam int POS_W           = 6;
    localparam int SIDE_RESET      = 64;
    localparam int NBR_W           = 8;

    localparam int BIRTH_COUNT     = 3;
    localparam int SURVIVE_COUNT   = 2;

    // Result slots of one input cell, in output order.
    localparam int SLOT_UP_LEFT = 0;   // (r-1, c-1)
    localparam int SLOT_UP      = 1;   // (r-1, c)   at row end
    localparam int SLOT_LEFT    = 2;   // (r,   c-1) on last row
    localparam int SLOT_HERE    = 3;   // (r,   c)   last cell
    localparam int SLOT_N       = 4;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [SLOT_N-1:0] present;
        logic [SLOT_N-1:0] alive;
    } bundle_t;

    function automatic logic life_next(input logic center, input logic [NBR_W-1:0] nbrs);
        logic [3:0] cnt;
        cnt = '0;
        for (int i = 0; i < NBR_W; i++)
        begin
            cnt = cnt + 4'(nbrs[i]);
        end
        return (cnt == 4'(BIRTH_COUNT)) || ((cnt == 4'(SURVIVE_COUNT)) && center);
    endfunction

endpackage

### rtl/lgs_front.sv
// ---------------------------------------------------------------------------
// lgs_front
// Accepts cells, keeps position, line stores and window, forms bundles.
// ---------------------------------------------------------------------------
module lgs_front #(
    parameter int GRID_MAX = lgs_pkg::GRID_MAX_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [lgs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       push,
    input  logic                       cell_alive,
    output logic                       full,
    output logic                       q_push,
    output lgs_pkg::bundle_t           q_data,
    input  logic                       q_full
);
    import lgs_pkg::*;

    localparam int IDX_W  = $clog2(GRID_MAX);
    localparam int SIDE_W = $clog2(GRID_MAX + 1);

    logic [CFG_W-1:0]  grid_side_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;
    logic [SIDE_W-1:0] side;
    logic [IDX_W-1:0]  side_last;
    logic [IDX_W-1:0]  row_cur, col_cur;
    logic              accept;

    // line stores
    logic newer_mem [GRID_MAX];
    logic older_mem [GRID_MAX];
    logic top_rd_reg, mid_rd_reg;

    // window stage
    logic             b_valid_reg;
    logic [IDX_W-1:0] b_row_reg, b_col_reg;
    logic             b_bot_reg;
    logic [2:0]       col_a_reg, col_b_reg;   // bit 0 top, 1 mid, 2 bottom
    logic [2:0]       col_a, col_b, col_c;
    logic             top, mid;
    logic             b_has, b_fire;
    logic             row_ge1, col_ge1, row_last, col_last;

    always_comb
    begin
        if (grid_side_reg == '0)
        begin
            side = SIDE_W'(1);
        end
        else if (32'(grid_side_reg) > GRID_MAX)
        begin
            side = SIDE_W'(GRID_MAX);
        end
        else
        begin
            side = SIDE_W'(grid_side_reg);
        end
    end

    assign side_last = IDX_W'(side - SIDE_W'(1));

    always_comb
    begin
        if ((row_reg > side_last) || (col_reg > side_last))
        begin
            row_cur = '0;
            col_cur = '0;
        end
        else
        begin
            row_cur = row_reg;
            col_cur = col_reg;
        end
    end

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= CFG_W'(SIDE_RESET);
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            grid_side_reg <= cfg_data;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else if (accept)
        begin
            if (col_cur >= side_last)
            begin
                col_reg <= '0;
                row_reg <= (row_cur >= side_last) ? '0 : row_cur + IDX_W'(1);
            end
            else
            begin
                col_reg <= col_cur + IDX_W'(1);
                row_reg <= row_cur;
            end
        end
    end

    // read-before-write on the newer store; older store takes mid on b_fire
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            newer_mem[col_cur] <= cell_alive;
            mid_rd_reg         <= newer_mem[col_cur];
            top_rd_reg         <= older_mem[col_cur];
        end
        if (b_fire)
        begin
            older_mem[b_col_reg] <= mid;
        end
    end

    assign top = (b_row_reg > IDX_W'(1)) && top_rd_reg;
    assign mid = (b_row_reg != '0) && mid_rd_reg;

    assign row_ge1  = (b_row_reg != '0);
    assign col_ge1  = (b_col_reg != '0);
    assign row_last = (b_row_reg == side_last);
    assign col_last = (b_col_reg == side_last);

    assign col_c = {b_bot_reg, mid, top};
    assign col_a = col_ge1 ? col_a_reg : 3'b000;
    assign col_b = col_ge1 ? col_b_reg : 3'b000;

    always_comb
    begin
        q_data = '0;
        q_data.row = POS_W'(b_row_reg);
        q_data.col = POS_W'(b_col_reg);
        q_data.present[SLOT_UP_LEFT] = row_ge1 && col_ge1;
        q_data.present[SLOT_UP]      = row_ge1 && col_last;
        q_data.present[SLOT_LEFT]    = row_last && col_ge1;
        q_data.present[SLOT_HERE]    = row_last && col_last;
        q_data.alive[SLOT_UP_LEFT] = life_next(col_b[1],
            {col_a, col_c, col_b[0], col_b[2]});
        q_data.alive[SLOT_UP]      = life_next(col_c[1],
            {col_b, col_c[0], col_c[2], 3'b000});
        q_data.alive[SLOT_LEFT]    = life_next(col_b[2],
            {col_a[2:1], col_c[2:1], col_b[1], 3'b000});
        q_data.alive[SLOT_HERE]    = life_next(col_c[2],
            {col_b[2:1], col_c[1], 5'b00000});
    end

    assign b_has  = |q_data.present;
    assign b_fire = b_valid_reg && (!b_has || !q_full);
    assign q_push = b_fire && b_has;
    assign full   = b_valid_reg && !b_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_row_reg <= row_cur;
            b_col_reg <= col_cur;
            b_bot_reg <= cell_alive;
        end
        if (b_fire)
        begin
            col_a_reg <= col_b;
            col_b_reg <= col_c;
        end
    end

endmodule

### rtl/lgs_fifo.sv
// ---------------------------------------------------------------------------
// lgs_fifo
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module lgs_fifo #(
    parameter int DEPTH = lgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lgs_pkg::bundle_t data_in,
    output logic             full,
    input  logic             pop,
    output lgs_pkg::bundle_t data_out,
    output logic             empty
);
    import lgs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

### rtl/lgs_back.sv
// ---------------------------------------------------------------------------
// lgs_back
// Unpacks request bundles into single results through an output register.
// ---------------------------------------------------------------------------
module lgs_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  lgs_pkg::bundle_t           q_data,
    output logic                       q_pop,
    output logic [lgs_pkg::POS_W-1:0]  out_row,
    output logic [lgs_pkg::POS_W-1:0]  out_col,
    output logic                       next_alive,
    output logic                       burst_end,
    output logic                       frame_end,
    output logic                       empty,
    input  logic                       pop
);
    import lgs_pkg::*;

    logic [SLOT_N-1:0] sent_reg;
    logic [SLOT_N-1:0] remain, remain_after;
    logic [1:0]        pick;
    logic              load;
    logic              out_valid_reg;
    logic [POS_W-1:0]  row_next, col_next;
    logic [POS_W-1:0]  row_reg, col_reg;
    logic              alive_reg, burst_reg, frame_reg;

    assign remain = q_data.present & ~sent_reg;

    always_comb
    begin
        if (remain[SLOT_UP_LEFT])
        begin
            pick = 2'(SLOT_UP_LEFT);
        end
        else if (remain[SLOT_UP])
        begin
            pick = 2'(SLOT_UP);
        end
        else if (remain[SLOT_LEFT])
        begin
            pick = 2'(SLOT_LEFT);
        end
        else
        begin
            pick = 2'(SLOT_HERE);
        end
    end

    assign remain_after = remain & ~(SLOT_N'(1) << pick);

    always_comb
    begin
        case (pick)
            2'(SLOT_UP_LEFT):
            begin
                row_next = q_data.row - POS_W'(1);
                col_next = q_data.col - POS_W'(1);
            end
            2'(SLOT_UP):
            begin
                row_next = q_data.row - POS_W'(1);
                col_next = q_data.col;
            end
            2'(SLOT_LEFT):
            begin
                row_next = q_data.row;
                col_next = q_data.col - POS_W'(1);
            end
            default:
            begin
                row_next = q_data.row;
                col_next = q_data.col;
            end
        endcase
    end

    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = load && (remain_after == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sent_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                sent_reg      <= q_pop ? '0 : (sent_reg | (SLOT_N'(1) << pick));
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            alive_reg <= q_data.alive[pick];
            burst_reg <= (remain_after == '0);
            frame_reg <= (pick == 2'(SLOT_HERE));
        end
    end

    assign empty      = !out_valid_reg;
    assign out_row    = row_reg;
    assign out_col    = col_reg;
    assign next_alive = alive_reg;
    assign burst_end  = burst_reg;
    assign frame_end  = frame_reg;

endmodule

### rtl/life_generation_stream.sv
// ---------------------------------------------------------------------------
// life_generation_stream - one Conway Life (B3/S23) generation over a stream
// Path: a cell's results pass the window stage, the bundle queue and the output register.
// Rate: one cell, one result per cycle unless stalled; multi-result cells fill the queue.
// Reset: async low; side 64, position (0,0), queues empty, no clearing pass.
// ---------------------------------------------------------------------------
//
// Structure
//   front : position counters, the two line stores (one memory each, registered
//           read), the 3x3 window and the Life rule. Each cell with results
//           becomes one request bundle holding them, up to four; others push none.
//   fifo  : short bundle queue, so the front and the back stall on their own.
//   back  : hands out the results of the head bundle through an output register,
//           one per cycle while popped; the next result loads while the current is popped.
//
// Rate
//   Results run one row and one column behind the input. Row-end cells below
//   row 0 and every cell of the last row except its first give two results,
//   the last cell gives four and the first cell of the last row none; at
//   side 1 each cell gives one. The back moves at most one result per cycle,
//   so during those stretches the bundle queue fills and full rises until the
//   back catches up; row 0 of the next frame gives no results and drains it.
//
// Configuration
//   cfg_data is the grid side; a write restarts the frame at cell (0, 0).
//   A side of 0 acts as 1, a side above GRID_MAX acts as GRID_MAX.
//   Line store contents from earlier frames are never used: rows above the
//   grid are masked as dead, so the stores need no clearing.
// ---------------------------------------------------------------------------
module life_generation_stream #(
    parameter int GRID_MAX    = lgs_pkg::GRID_MAX_DEF,
    parameter int QUEUE_DEPTH = lgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lgs_pkg::CFG_W-1:0]  cfg_data,
    // cell input
    input  logic                       push,
    output logic                       full,
    input  logic                       cell_alive,
    // result output
    output logic                       empty,
    input  logic                       pop,
    output logic [lgs_pkg::POS_W-1:0]  out_row,
    output logic [lgs_pkg::POS_W-1:0]  out_col,
    output logic                       next_alive,
    output logic                       burst_end,
    output logic                       frame_end
);
    import lgs_pkg::*;

    bundle_t q_in_data, q_out_data;
    logic    q_push, q_full, q_pop, q_empty;

    // Writes must only be made while the block is idle; it does not check and takes them all.
    assign cfg_ready = 1'b1;

    lgs_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .push       (push),
        .cell_alive (cell_alive),
        .full       (full),
        .q_push     (q_push),
        .q_data     (q_in_data),
        .q_full     (q_full)
    );

    lgs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_in_data),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out_data),
        .empty    (q_empty)
    );

    lgs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out_data),
        .q_pop      (q_pop),
        .out_row    (out_row),
        .out_col    (out_col),
        .next_alive (next_alive),
        .burst_end  (burst_end),
        .frame_end  (frame_end),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

### rtl/lgs_checker.sv
// ---------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the Life generation stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lgs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [lgs_pkg::POS_W-1:0]  out_row,
    input logic [lgs_pkg::POS_W-1:0]  out_col,
    input logic                       next_alive,
    input logic                       burst_end,
    input logic                       frame_end
);

    // last cell of the frame closes its burst
    `LGS_ASSERT(a_frame_closes_burst, clk, rst_n, (!empty && frame_end) |-> burst_end, "frame_end without burst_end")

    // last cell sits on the diagonal
    `LGS_ASSERT(a_frame_on_diag, clk, rst_n, (!empty && frame_end) |-> (out_row == out_col), "frame_end off the diagonal")

    // a burst keeps coming once started
    `LGS_ASSERT(a_burst_gapless, clk, rst_n, (!empty && pop && !burst_end) |=> !empty, "gap inside a burst")

    // a waiting result holds
    `LGS_ASSERT(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_row) && $stable(out_col) && $stable(next_alive)), "result changed while stalled")

    // nothing offered in reset
    `LGS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> empty, "result offered during reset")

endmodule

bind life_generation_stream lgs_checker u_checker (.*);

### verif/life_generation_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_generation_stream_checker
// Watches the side, cell and result channels, predicts the next-generation
// results of every accepted cell request and compares each popped result
// with the oldest prediction.
// ---------------------------------------------------------------------------
module life_generation_stream_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lgs_pkg::CFG_W-1:0] cfg_data,
    input  logic                      push,
    input  logic                      full,
    input  logic                      cell_alive,
    input  logic                      empty,
    input  logic                      pop,
    input  logic [lgs_pkg::POS_W-1:0] out_row,
    input  logic [lgs_pkg::POS_W-1:0] out_col,
    input  logic                      next_alive,
    input  logic                      burst_end,
    input  logic                      frame_end,
    output int                        pending,
    output int                        fail_count
);
    import lgs_pkg::*;

    localparam int GRID_MAX = GRID_MAX_DEF;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             alive;
        logic             burst_end;
        logic             frame_end;
    } life_result_t;

    life_result_t     next_gen_q[$];
    logic [CFG_W-1:0] side_reg;
    logic             older_line [GRID_MAX];   // row r-2
    logic             newer_line [GRID_MAX];   // row r-1
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [2:0]       win_col [3];             // [0] = column c-2; bit 0 top, 2 bottom
    int               mismatches = 0;

    // 4x4 view of the window: row 3 and column 3 lie beyond the edge
    function automatic logic win_cell(int rr, int cc);
        if (rr > 2 || cc > 2)
        begin
            return 1'b0;
        end
        return win_col[cc][rr];
    endfunction

    function automatic logic rule_next(int rr, int cc);
        int n;
        n = 0;
        for (int i = rr - 1; i <= rr + 1; i++)
        begin
            for (int j = cc - 1; j <= cc + 1; j++)
            begin
                if (i != rr || j != cc)
                begin
                    n += int'(win_cell(i, j));
                end
            end
        end
        if (n == BIRTH_COUNT)
        begin
            return 1'b1;
        end
        if (n == SURVIVE_COUNT)
        begin
            return win_cell(rr, cc);
        end
        return 1'b0;
    endfunction

    function automatic life_result_t make_result(int unsigned r, int unsigned c,
                                                 logic alive, logic last_cell);
        life_result_t res;
        res.row       = POS_W'(r);
        res.col       = POS_W'(c);
        res.alive     = alive;
        res.burst_end = 1'b0;
        res.frame_end = last_cell;
        return res;
    endfunction

    task automatic predict_cell(input logic bot);
        int unsigned  side;
        int unsigned  r;
        int unsigned  c;
        logic         top;
        logic         mid;
        life_result_t res [4];
        int           k;
        if (side_reg == '0)
        begin
            side = 1;
        end
        else if (int'(side_reg) > GRID_MAX)
        begin
            side = GRID_MAX;
        end
        else
        begin
            side = int'(side_reg);
        end
        r = row_pos;
        c = col_pos;
        if (r >= side || c >= side)
        begin
            r = 0;
            c = 0;
        end

        // rows above the grid read dead, whatever the line stores hold
        top = (r >= 2) ? older_line[c] : 1'b0;
        mid = (r >= 1) ? newer_line[c] : 1'b0;
        older_line[c] = mid;
        newer_line[c] = bot;

        if (c == 0)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win_col[j] = '0;
            end
        end
        win_col[0] = win_col[1];
        win_col[1] = win_col[2];
        win_col[2] = {bot, mid, top};

        k = 0;
        if (r >= 1 && c >= 1)
        begin
            res[k] = make_result(r - 1, c - 1, rule_next(1, 1), 1'b0);
            k++;
        end
        if (r >= 1 && c == side - 1)
        begin
            res[k] = make_result(r - 1, c, rule_next(1, 2), 1'b0);
            k++;
        end
        if (r == side - 1 && c >= 1)
        begin
            res[k] = make_result(r, c - 1, rule_next(2, 1), 1'b0);
            k++;
        end
        if (r == side - 1 && c == side - 1)
        begin
            res[k] = make_result(r, c, rule_next(2, 2), 1'b1);
            k++;
        end
        if (k > 0)
        begin
            res[k - 1].burst_end = 1'b1;
        end
        for (int i = 0; i < k; i++)
        begin
            next_gen_q.push_back(res[i]);
        end

        if (c + 1 >= side)
        begin
            c = 0;
            r = (r + 1 >= side) ? 0 : r + 1;
        end
        else
        begin
            c = c + 1;
        end
        row_pos = r;
        col_pos = c;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        life_result_t want;
        if (!rst_n)
        begin
            next_gen_q.delete();
            side_reg = CFG_W'(SIDE_RESET);
            for (int i = 0; i < GRID_MAX; i++)
            begin
                older_line[i] = 1'b0;
                newer_line[i] = 1'b0;
            end
            for (int j = 0; j < 3; j++)
            begin
                win_col[j] = '0;
            end
            row_pos = 0;
            col_pos = 0;
            pending <= 0;
        end
        else
        begin
            // a side write restarts the frame at cell (0, 0)
            if (cfg_valid && cfg_ready)
            begin
                side_reg = cfg_data;
                row_pos  = 0;
                col_pos  = 0;
            end
            if (push && !full)
            begin
                predict_cell(cell_alive);
            end
            if (pop && !empty)
            begin
                if (next_gen_q.size() == 0)
                begin
                    $error("result (%0d, %0d) popped with nothing predicted", out_row, out_col);
                    mismatches++;
                end
                else
                begin
                    want = next_gen_q.pop_front();
                    if (out_row !== want.row)
                    begin
                        $error("out_row: expected %0d, actual %0d", want.row, out_row);
                        mismatches++;
                    end
                    if (out_col !== want.col)
                    begin
                        $error("out_col: expected %0d, actual %0d", want.col, out_col);
                        mismatches++;
                    end
                    if (next_alive !== want.alive)
                    begin
                        $error("next_alive: expected %0b, actual %0b", want.alive, next_alive);
                        mismatches++;
                    end
                    if (burst_end !== want.burst_end)
                    begin
                        $error("burst_end: expected %0b, actual %0b", want.burst_end, burst_end);
                        mismatches++;
                    end
                    if (frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
                        mismatches++;
                    end
                end
            end
            pending    <= next_gen_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

### verif/life_generation_stream_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// life_generation_stream_tb
// Drives cell requests and grid side writes into the Life generation stream
// and lets the checker score every result. A short directed part covers the
// reset side, side 0, a full 2x2 frame, a blinker and a clamped side; random
// phases then run whole frames, cut frames and a few wide grids, with bursty
// push and a receiver that stalls on its own pattern.
// ---------------------------------------------------------------------------
module life_generation_stream_tb;
    import lgs_pkg::*;

    localparam int RANDOM_CELLS = 88;      // random cell requests to send
    localparam int DRAIN_CYCLES = 12;      // window stage, bundle queue and output register
    localparam int LIMIT_CYCLES = 400000;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             push;
    logic             full;
    logic             cell_alive;
    logic             empty;
    logic             pop;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             next_alive;
    logic             burst_end;
    logic             frame_end;

    int               pending;
    int               fail_count;
    int               cycle_count = 0;
    int               burst_left  = 0;
    int               cells_sent  = 0;

    life_generation_stream DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .cell_alive (cell_alive),
        .empty      (empty),
        .pop        (pop),
        .out_row    (out_row),
        .out_col    (out_col),
        .next_alive (next_alive),
        .burst_end  (burst_end),
        .frame_end  (frame_end)
    );

    life_generation_stream_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .cell_alive (cell_alive),
        .empty      (empty),
        .pop        (pop),
        .out_row    (out_row),
        .out_col    (out_col),
        .next_alive (next_alive),
        .burst_end  (burst_end),
        .frame_end  (frame_end),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: picks a stall pattern for a stretch of cycles, then another.
    // Mode 0 never stalls, 1 pops half the time, 2 a quarter, 3 stalls in
    // long runs so the bundle queue backs up into full.
    initial
    begin
        int mode;
        int span;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 80);
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= ((k % 12) >= 9);
                endcase
            end
        end
    end

    // Sends a cell request and waits until the block takes it. Gaps go in
    // between bursts of random length.
    task automatic send_cell(input logic alive);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push       <= 1'b1;
        cell_alive <= alive;
        do
            @(posedge clk);
        while (full);
        cells_sent++;
    endtask

    // Cells in raster order, bit 0 first.
    task automatic send_pattern(input logic [15:0] bits, input int n);
        for (int i = 0; i < n; i++)
        begin
            send_cell(bits[i]);
        end
    endtask

    // Block idle: no request in flight, every predicted result popped, and
    // time for cells that make no result to leave the front.
    task automatic settle();
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Side write; only issued once settle() has run.
    task automatic write_side(input logic [CFG_W-1:0] side);
        cfg_valid <= 1'b1;
        cfg_data  <= side;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // budget: cells still to send in the random part
    task automatic random_phase(input int budget);
        int sel;
        int side;
        int eff;
        int n;
        int density;
        sel = $urandom_range(0, 19);
        if (sel < 12)
        begin
            side = $urandom_range(1, 5);
        end
        else if (sel < 15)
        begin
            side = $urandom_range(6, 9);
        end
        else if (sel == 15)
        begin
            side = 0;
        end
        else if (sel == 16)
        begin
            side = GRID_MAX_DEF;
        end
        else if (sel == 17)
        begin
            side = $urandom_range(GRID_MAX_DEF + 1, (1 << CFG_W) - 1);
        end
        else if (sel == 18)
        begin
            side = 1;
        end
        else
        begin
            side = $urandom_range(0, (1 << CFG_W) - 1);
        end
        eff = (side == 0) ? 1 : ((side > GRID_MAX_DEF) ? GRID_MAX_DEF : side);

        if (eff > 9)
        begin
            // wide grid: just past row 0 so a handful of results come out
            n = eff + $urandom_range(1, 6);
        end
        else
        begin
            n = ((eff <= 5) ? $urandom_range(1, 2) : 1) * eff * eff;
            // now and then cut the frame short; the next write restarts it
            if ($urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, n);
            end
        end
        if (n > budget)
        begin
            n = budget;
        end
        density = $urandom_range(15, 85);

        settle();
        write_side(CFG_W'(side));
        for (int i = 0; i < n; i++)
        begin
            send_cell($urandom_range(0, 99) < density);
        end
    endtask

    initial
    begin
        int random_start;
        rst_n      <= 1'b0;
        push       <= 1'b0;
        cell_alive <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset side 64: row 0 only, so nothing comes out; the next write
        // lands mid-frame.
        send_pattern(16'b101, 3);

        // Side 0 acts as 1: every cell is a whole frame with no neighbours.
        settle();
        write_side(CFG_W'(0));
        send_pattern(16'b101, 3);

        // 2x2 all live: each cell has three neighbours, last cell bursts four.
        settle();
        write_side(CFG_W'(2));
        send_pattern(16'b1111, 4);

        // 3x3 blinker: vertical bar turns horizontal, births and deaths.
        settle();
        write_side(CFG_W'(3));
        send_pattern(16'b010_010_010, 9);

        // Side above the limit acts as 64; stopped mid-row.
        settle();
        write_side('1);
        send_pattern(16'b0110, 4);

        random_start = cells_sent;
        while (cells_sent - random_start < RANDOM_CELLS)
        begin
            random_phase(RANDOM_CELLS - (cells_sent - random_start));
        end

        settle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
